/* design/ffha_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

    // Arena geometry
    localparam int ARENA_BYTES = 4096;
    localparam int AW          = $clog2(ARENA_BYTES);   // byte offset width
    localparam int PW          = AW + 2;                 // width for chain sums
    localparam int SW          = 12;                     // payload size width
    localparam int HDR_BYTES   = 4;
    localparam int LAST_HDR    = ARENA_BYTES - HDR_BYTES;
    localparam int MIN_SPLIT   = HDR_BYTES + 1;          // header plus one byte

    // Operation codes
    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOMEM   = 3'd1,
        ST_BADSIZE = 3'd2,
        ST_BADPTR  = 3'd3,
        ST_BOUNDS  = 3'd4
    } status_t;

    // In-band block header
    typedef struct packed {
        logic          alloc;
        logic [SW-1:0] size;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    // Classified request handed from front to back
    typedef struct packed {
        func_t         func;
        logic [SW-1:0] request_size;
        logic [11:0]   block_offset;
        logic          zero_size;
        logic          out_of_bounds;
    } cmd_t;

endpackage

/* design/ffha_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/ffha_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and queues them two deep.
// Depends on ffha_pkg.
module ffha_front
    import ffha_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          func,
    input  logic [SW-1:0] request_size,
    input  logic [11:0]   block_offset,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  logic          cmd_pop
);

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;
    cmd_t        cls;

    // classify the incoming request
    always_comb
    begin
        cls.func          = func_t'(func);
        cls.request_size  = request_size;
        cls.block_offset  = block_offset;
        cls.zero_size     = (request_size == '0);
        cls.out_of_bounds = (block_offset < 12'(HDR_BYTES));
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* design/ffha_back.sv */
`timescale 1ns / 1ps
// Back end: walks the header chain in the arena RAM, performs allocate or
// free, and holds the result until popped. Depends on ffha_pkg, ffha_ram.
module ffha_back
    import ffha_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cmd_t          cmd,
    output logic          cmd_pop,
    output logic          empty,
    input  logic          pop,
    output logic [11:0]   result_offset,
    output logic [2:0]    status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_ISSUE,
        S_A_EVAL,
        S_F_ISSUE,
        S_F_WALK,
        S_F_HDR,
        S_F_NXT,
        S_WR2
    } state_t;

    state_t          state_reg;
    cmd_t            cmd_reg;
    logic [PW-1:0]   i_reg;
    logic [AW-1:0]   prev_reg;
    logic [SW-1:0]   prev_size_reg;
    logic            prev_alloc_reg;
    logic            have_prev_reg;
    logic [SW-1:0]   s_reg;
    logic [AW-1:0]   wr_addr_reg;
    logic [SW-1:0]   wr_size_reg;
    logic            formatted_reg;
    logic            res_valid_reg;
    logic [11:0]     res_off_reg;
    status_t         res_status_reg;

    logic            we;
    logic [AW-1:0]   waddr;
    hdr_t            wdata;
    logic [AW-1:0]   raddr;
    logic [HDR_W-1:0] rdata_raw;
    hdr_t            hdr;

    logic            start;
    logic [PW-1:0]   h;
    logic [PW-1:0]   chain_next;
    logic            fits;
    logic [SW-1:0]   rem;
    logic            split;
    logic [PW-1:0]   succ;
    logic            succ_in;
    logic [SW-1:0]   s_new;
    logic            prev_free;

    ffha_ram #(
        .WIDTH (HDR_W),
        .DEPTH (ARENA_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign hdr = hdr_t'(rdata_raw);

    // datapath terms
    always_comb
    begin
        start      = (state_reg == S_IDLE) && cmd_valid && !res_valid_reg;
        h          = PW'(cmd_reg.block_offset) - PW'(HDR_BYTES);
        chain_next = i_reg + PW'(HDR_BYTES) + PW'(hdr.size);
        fits       = !hdr.alloc && (hdr.size >= cmd_reg.request_size);
        rem        = hdr.size - cmd_reg.request_size;
        split      = (rem >= SW'(MIN_SPLIT));
        succ       = h + PW'(HDR_BYTES) + PW'(hdr.size);
        succ_in    = (succ <= PW'(LAST_HDR));
        s_new      = hdr.alloc ? s_reg : (s_reg + SW'(HDR_BYTES) + hdr.size);
        prev_free  = have_prev_reg && !prev_alloc_reg;
    end

    // read address: successor lookup in S_F_HDR, chain cursor otherwise
    assign raddr = (state_reg == S_F_HDR) ? succ[AW-1:0] : i_reg[AW-1:0];

    // header write port
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && cmd.func == FUNC_ALLOC && !formatted_reg)
                begin
                    we         = 1'b1;
                    wdata.size = SW'(LAST_HDR);
                end
            end
            S_A_EVAL:
            begin
                if (fits)
                begin
                    we          = 1'b1;
                    waddr       = i_reg[AW-1:0];
                    wdata.alloc = 1'b1;
                    wdata.size  = split ? cmd_reg.request_size : hdr.size;
                end
            end
            S_F_HDR:
            begin
                if (hdr.alloc && !succ_in)
                begin
                    we         = 1'b1;
                    waddr      = h[AW-1:0];
                    wdata.size = hdr.size;
                end
            end
            S_F_NXT:
            begin
                we         = 1'b1;
                waddr      = h[AW-1:0];
                wdata.size = s_new;
            end
            S_WR2:
            begin
                we         = 1'b1;
                waddr      = wr_addr_reg;
                wdata.size = wr_size_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign cmd_pop       = start;
    assign empty         = !res_valid_reg;
    assign result_offset = res_off_reg;
    assign status        = res_status_reg;

    // sequencer: state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            formatted_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            prev_alloc_reg <= 1'b0;
            res_off_reg    <= '0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg       <= cmd;
                        i_reg         <= '0;
                        have_prev_reg <= 1'b0;
                        res_off_reg   <= '0;
                        if (cmd.func == FUNC_ALLOC)
                        begin
                            formatted_reg <= 1'b1;
                            if (cmd.zero_size)
                            begin
                                res_status_reg <= ST_BADSIZE;
                                res_valid_reg  <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_A_ISSUE;
                            end
                        end
                        else if (cmd.out_of_bounds)
                        begin
                            res_status_reg <= ST_BOUNDS;
                            res_valid_reg  <= 1'b1;
                        end
                        else if (!formatted_reg)
                        begin
                            res_status_reg <= ST_BADPTR;
                            res_valid_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_F_ISSUE;
                        end
                    end
                end
                S_A_ISSUE:
                begin
                    // chain exhausted
                    if (i_reg > PW'(LAST_HDR))
                    begin
                        res_status_reg <= ST_NOMEM;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_A_EVAL;
                    end
                end
                S_A_EVAL:
                begin
                    if (fits)
                    begin
                        res_off_reg    <= 12'(i_reg + PW'(HDR_BYTES));
                        res_status_reg <= ST_OK;
                        if (split)
                        begin
                            wr_addr_reg <= AW'(i_reg + PW'(HDR_BYTES)
                                               + PW'(cmd_reg.request_size));
                            wr_size_reg <= rem - SW'(HDR_BYTES);
                            state_reg   <= S_WR2;
                        end
                        else
                        begin
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                    begin
                        i_reg     <= chain_next;
                        state_reg <= S_A_ISSUE;
                    end
                end
                S_F_ISSUE:
                begin
                    priority if (i_reg == h)
                    begin
                        state_reg <= S_F_HDR;
                    end
                    else if (i_reg < h)
                    begin
                        state_reg <= S_F_WALK;
                    end
                    else
                    begin
                        res_status_reg <= ST_BADPTR;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_F_WALK:
                begin
                    // remember predecessor and step along the chain
                    prev_reg       <= i_reg[AW-1:0];
                    prev_size_reg  <= hdr.size;
                    prev_alloc_reg <= hdr.alloc;
                    have_prev_reg  <= 1'b1;
                    i_reg          <= chain_next;
                    state_reg      <= S_F_ISSUE;
                end
                S_F_HDR:
                begin
                    // a header marked free here is a double free
                    res_status_reg <= hdr.alloc ? ST_OK : ST_BADPTR;
                    s_reg          <= hdr.size;
                    if (!hdr.alloc)
                    begin
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else if (succ_in)
                    begin
                        state_reg <= S_F_NXT;
                    end
                    else if (prev_free)
                    begin
                        wr_addr_reg <= prev_reg;
                        wr_size_reg <= prev_size_reg + SW'(HDR_BYTES) + hdr.size;
                        state_reg   <= S_WR2;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_F_NXT:
                begin
                    // h freed this cycle, merged with a free successor; predecessor next
                    if (prev_free)
                    begin
                        wr_addr_reg <= prev_reg;
                        wr_size_reg <= prev_size_reg + SW'(HDR_BYTES) + s_new;
                        state_reg   <= S_WR2;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_WR2:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// Top level of the first-fit heap allocator: front queue plus back engine.
// Depends on ffha_pkg, ffha_front, ffha_back.
//
//  channel   | handshake        | fields
//  ----------+------------------+-----------------------------------------
//  request   | push / full      | func, request_size, block_offset
//  result    | pop / empty      | result_offset, status
//
// A request reads one header per block visited on the chain (one RAM read
// each), besides starting up and writing back headers.
// Reset clears the queues, the engine and the formatted flag; arena headers
// are written on the first allocate. Up to two requests queue ahead of the
// engine, and one result waits in the output register until popped.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          func,
    input  logic [SW-1:0] request_size,
    input  logic [11:0]   block_offset,
    output logic          empty,
    input  logic          pop,
    output logic [11:0]   result_offset,
    output logic [2:0]    status
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    ffha_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .request_size (request_size),
        .block_offset (block_offset),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    ffha_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .empty         (empty),
        .pop           (pop),
        .result_offset (result_offset),
        .status        (status)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for first_fit_heap_allocator: directed and random allocate/free
// requests with a heap model and a scoreboard class. Depends on ffha_pkg and the RTL.
module tb;
    import ffha_pkg::*;

    typedef struct packed {
        logic [11:0] offset;
        status_t     st;
    } heap_result_t;

    // Result queue and mismatch accounting
    class heap_scoreboard;
        heap_result_t pending[$];
        int errors;
        int checked;

        function void note_request(heap_result_t r);
            pending.push_back(r);
        endfunction

        function void check_result(logic [11:0] offset, logic [2:0] st);
            heap_result_t exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result offset=%0d status=%0d", offset, st);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (exp_r.offset !== offset || exp_r.st !== st) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp offset=%0d status=%0d, got offset=%0d status=%0d",
                             exp_r.offset, exp_r.st, offset, st);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        func = 1'b0;
    logic [11:0] request_size = '0;
    logic [11:0] block_offset = '0;
    logic        full, empty;
    logic [11:0] result_offset;
    logic [2:0]  status;

    first_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .request_size(request_size), .block_offset(block_offset),
        .empty(empty), .pop(pop), .result_offset(result_offset), .status(status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Heap model: header per byte offset
    logic [11:0] hdr_size[ARENA_BYTES];
    logic        hdr_alloc[ARENA_BYTES];
    bit          formatted;
    int          live[$];          // payload offsets currently allocated

    heap_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles = 0;
    bit done_sending;

    function automatic heap_result_t model_alloc(int size);
        heap_result_t r;
        int i;
        int bs;
        int rem;
        r.offset = '0;
        if (!formatted) begin
            hdr_size[0] = 12'(ARENA_BYTES - 4);
            hdr_alloc[0] = 1'b0;
            formatted = 1'b1;
        end
        if (size == 0) begin
            r.st = ST_BADSIZE;
            return r;
        end
        i = 0;
        while (i + 4 <= ARENA_BYTES) begin
            bs = int'(hdr_size[i]);
            if (!hdr_alloc[i] && bs >= size) begin
                rem = bs - size;
                hdr_alloc[i] = 1'b1;
                if (rem >= MIN_SPLIT) begin
                    hdr_size[i] = 12'(size);
                    if (i + 4 + size < ARENA_BYTES) begin
                        hdr_size[i + 4 + size] = 12'(rem - 4);
                        hdr_alloc[i + 4 + size] = 1'b0;
                    end
                end
                r.offset = 12'(i + 4);
                r.st = ST_OK;
                live.push_back(i + 4);
                return r;
            end
            i = i + 4 + bs;
        end
        r.st = ST_NOMEM;
        return r;
    endfunction

    function automatic heap_result_t model_free(int off);
        heap_result_t r;
        int h;
        int i;
        int s;
        int nxt;
        int prev;
        bit have_prev;
        r.offset = '0;
        i = 0;
        prev = 0;
        have_prev = 1'b0;
        if (off < 4 || off - 4 > LAST_HDR) begin
            r.st = ST_BOUNDS;
            return r;
        end
        h = off - 4;
        if (!formatted) begin
            r.st = ST_BADPTR;
            return r;
        end
        while (i + 4 <= ARENA_BYTES && i < h) begin
            prev = i;
            have_prev = 1'b1;
            i = i + 4 + int'(hdr_size[i]);
        end
        if (i != h || !hdr_alloc[h]) begin
            r.st = ST_BADPTR;
            return r;
        end
        s = int'(hdr_size[h]);
        nxt = h + 4 + s;
        if (nxt + 4 <= ARENA_BYTES && !hdr_alloc[nxt])
            s = s + 4 + int'(hdr_size[nxt]);
        hdr_size[h] = 12'(s);
        hdr_alloc[h] = 1'b0;
        if (have_prev && !hdr_alloc[prev])
            hdr_size[prev] = 12'(int'(hdr_size[prev]) + 4 + s);
        foreach (live[k])
            if (live[k] == off) begin
                live.delete(k);
                break;
            end
        r.st = ST_OK;
        return r;
    endfunction

    // Drive one request and hold until accepted; push is left high so the
    // next request can follow with no gap
    task automatic send_request(func_t f, int size, int off);
        heap_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        func <= f;
        request_size <= size[11:0];
        block_offset <= off[11:0];
        do @(posedge clk); while (full);
        r = (f == FUNC_ALLOC) ? model_alloc(size) : model_free(off);
        sb.note_request(r);
    endtask

    // Random request: mostly well-formed allocate/free of live blocks
    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            if ($urandom_range(9) == 0)
                send_request(FUNC_ALLOC, $urandom_range(4092), 0);
            else
                send_request(FUNC_ALLOC, $urandom_range(1, 300), $urandom);
        end else if (pick < 85 && live.size() > 0) begin
            send_request(FUNC_FREE, $urandom, live[$urandom_range(live.size() - 1)]);
        end else if (pick < 92) begin
            send_request(FUNC_FREE, $urandom, $urandom_range(4095));
        end else begin
            send_request(($urandom_range(1) != 0) ? FUNC_FREE : FUNC_ALLOC, 0,
                         $urandom_range(3));
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, check on accept
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pop && !empty)
                sb.check_result(result_offset, status);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("timeout waiting on the allocator");
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        formatted = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: free before format, bounds, zero size, extremes
        send_request(FUNC_FREE, 0, 100);
        send_request(FUNC_FREE, 4095, 0);
        send_request(FUNC_FREE, 0, 3);
        send_request(FUNC_FREE, 0, 4095);
        send_request(FUNC_ALLOC, 0, 0);
        send_request(FUNC_ALLOC, 4095, 4095);
        send_request(FUNC_ALLOC, 4092, 0);
        send_request(FUNC_FREE, 0, 4);
        send_request(FUNC_FREE, 0, 4);
        send_request(FUNC_ALLOC, 4088, 0);
        send_request(FUNC_FREE, 0, 4);
        send_request(FUNC_ALLOC, 4085, 0);
        send_request(FUNC_FREE, 0, 4);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_ALLOC, 2048, 0);
        send_request(FUNC_ALLOC, 2048, 0);
        send_request(FUNC_ALLOC, 100, 0);
        send_request(FUNC_FREE, 0, 9);
        send_request(FUNC_FREE, 0, 5);
        send_request(FUNC_FREE, 0, 4);
        send_request(FUNC_FREE, 0, 4100 & 12'hfff);
        send_request(FUNC_FREE, 0, 12);

        // Pause until everything is back
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            repeat (107) random_request();
            // free everything so the last phase reaches a fully merged arena
            if (phase == 3)
                while (live.size() > 0)
                    send_request(FUNC_FREE, 0, live[0]);
        end

        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d results over four idle/stall mixes; %0d blocks still live",
                 sb.checked, live.size());
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
